@@ design/rpt_pkg.sv @@
package rpt_pkg;

   // Table geometry and field widths.
   localparam int DEPTH    = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int PID_W    = 32;
   localparam int STAMP_W  = 32;
   localparam int TYPE_W   = 8;

   localparam logic [STAMP_W-1:0] TIMEOUT_RESET = STAMP_W'(100);

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_POLL  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED     = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_ACKED     = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_TIMED_OUT = 3'd4,
      STAT_NONE_DUE  = 3'd5,
      STAT_CLEARED   = 3'd6
   } status_type;

   // One stored packet record.
   typedef struct packed {
      logic [TYPE_W-1:0]  ptype;
      logic [STAMP_W-1:0] stamp;
      logic [PID_W-1:0]   pid;
   } entry_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic             shift;
      logic             ins_en;
      logic [IDX_W-1:0] ins_idx;
      entry_type        ins_ent;
   } chain_ctl_type;

endpackage

@@ design/rpt_cell.sv @@
// One position of the queue. On a shift the cell takes its upstream
// neighbor's record; an insert aimed at this position takes priority.
module rpt_cell
   import rpt_pkg::*;
(
   input  logic          clock,
   input  logic [IDX_W-1:0] cell_idx,
   input  chain_ctl_type ctl,
   input  entry_type     up_ent,
   output entry_type     ent
);

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.ins_en && (ctl.ins_idx == cell_idx)) begin
         ent_in = ctl.ins_ent;
      end else if (ctl.shift) begin
         ent_in = up_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

@@ design/rpt_ctrl.sv @@
// Sequencer for the cell chain: decodes transactions, tracks the fill
// count, runs the acknowledge walk and holds the result register.
module rpt_ctrl
   import rpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  entry_type          req_ent,
   input  entry_type          head_ent,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [STAMP_W-1:0] csr_data,
   output chain_ctl_type      ctl,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output status_type         rsp_status,
   output entry_type          rsp_ent
);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type          state_ff,      state_in;
   logic [CNT_W-1:0]   count_ff,      count_in;
   logic [IDX_W-1:0]   step_ff,       step_in;
   logic               found_ff,      found_in;
   logic               done_ff,       done_in;
   logic [PID_W-1:0]   key_ff,        key_in;
   logic [STAMP_W-1:0] timeout_ff,    timeout_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   entry_type          rsp_ent_ff,    rsp_ent_in;

   logic               accept;
   logic               hit;
   logic               stop;
   logic [STAMP_W-1:0] age;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign hit       = !done_ff && (head_ent.pid == key_ff);
   assign stop      = !done_ff && (head_ent.pid > key_ff);
   assign age       = req_ent.stamp - head_ent.stamp;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      done_in       = done_ff;
      key_in        = key_ff;
      timeout_in    = timeout_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ent_in    = rsp_ent_ff;

      ctl         = '0;
      ctl.ins_ent = req_ent;

      if (csr_valid) begin
         timeout_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_ent_in = '0;
               case (kind_type'(req_kind))
                  KIND_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_W'(DEPTH)) begin
                        ctl.ins_en    = 1'b1;
                        ctl.ins_idx   = count_ff[IDX_W-1:0];
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STAT_ADDED;
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  KIND_ACK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        state_in = S_WALK;
                        key_in   = req_ent.pid;
                        step_in  = '0;
                        found_in = 1'b0;
                        done_in  = 1'b0;
                     end
                  end
                  KIND_POLL: begin
                     rsp_valid_in = 1'b1;
                     if ((count_ff != '0) && (age >= timeout_ff)) begin
                        ctl.shift     = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                        rsp_status_in = STAT_TIMED_OUT;
                        rsp_ent_in    = head_ent;
                     end else begin
                        rsp_status_in = STAT_NONE_DUE;
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     count_in      = '0;
                     rsp_status_in = STAT_CLEARED;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_CLEARED;
                  end
               endcase
            end
         end
         S_WALK: begin
            // The oldest record leaves the head cell each cycle and is fed
            // back behind the live entries, unless it is the one acked.
            ctl.shift = 1'b1;
            if (hit) begin
               found_in   = 1'b1;
               done_in    = 1'b1;
               rsp_ent_in = head_ent;
            end else begin
               ctl.ins_en  = 1'b1;
               ctl.ins_idx = IDX_W'(count_ff - CNT_W'(1) - CNT_W'(found_ff));
               ctl.ins_ent = head_ent;
            end
            if (stop) begin
               done_in = 1'b1;
            end
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(count_ff - CNT_W'(1))) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_in ? STAT_ACKED : STAT_NOT_FOUND;
               count_in      = count_ff - CNT_W'(found_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff       <= step_in;
      found_ff      <= found_in;
      done_ff       <= done_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ent_ff    <= rsp_ent_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_ent    = rsp_ent_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond table depth");

   a_ack_walks: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_ACK) && (count_ff != '0)) |=>
         (!rsp_valid_ff && (state_ff == S_WALK)))
      else $error("acknowledge on a filled table did not start a walk");

   a_walk_removes_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |=>
         ((count_ff == $past(count_ff)) || (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("walk changed the fill count by more than one");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_ADD) && (count_ff < CNT_W'(DEPTH))) |=>
         ((count_ff == $past(count_ff) + CNT_W'(1)) && (rsp_status_ff == STAT_ADDED)))
      else $error("add with room did not append");
`endif

endmodule

@@ design/retransmit_pending_table_unit.sv @@
// Retransmit pending table: holds up to DEPTH packets that still wait for an
// acknowledgement, oldest first, in a row of cells that each hold one record
// (packet id, send time, packet type). Every request transaction yields exactly
// one response transaction. An add, a poll or a clear is answered straight from
// the idle state. An acknowledge on a non-empty table first walks the ring: the
// records rotate through the head cell one per cycle, the head is compared with
// the id, and the matching record is dropped from the ring while the others
// return to the tail, so the walk length is set by the fill count. Requests are
// not taken during that walk. The response sits in an output register, and a
// new request is accepted in the same cycle that a pending response is taken.
// The timeout register is written through the csr channel, which is always
// ready; it resets to 100.
module retransmit_pending_table_unit
   import rpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   // Request transactions.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [KIND_W-1:0]  req_tuser,  // [1:0] kind
   input  logic [71:0]        req_tdata,  // [31:0] key_pid, [63:32] stamp, [71:64] pkt_type

   // Response transactions.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [STATUS_W-1:0] rsp_tuser, // [2:0] status
   output logic [71:0]        rsp_tdata,  // [31:0] out_pid, [63:32] out_stamp, [71:64] out_type

   // Timeout register writes.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [STAMP_W-1:0] csr_data
);

   entry_type     req_ent;
   entry_type     rsp_ent;
   status_type    rsp_status;
   chain_ctl_type ctl;
   entry_type     cell_ent [DEPTH];

   assign req_ent.pid   = req_tdata[31:0];
   assign req_ent.stamp = req_tdata[63:32];
   assign req_ent.ptype = req_tdata[71:64];

   // The cell chain: cell 0 holds the oldest entry, and a shift moves every
   // record one position toward it. The last cell recirculates its own record.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type up_ent;
      if (i == DEPTH - 1) begin : g_last
         assign up_ent = cell_ent[i];
      end else begin : g_mid
         assign up_ent = cell_ent[i+1];
      end
      rpt_cell u_cell (
         .clock    (clock),
         .cell_idx (IDX_W'(i)),
         .ctl      (ctl),
         .up_ent   (up_ent),
         .ent      (cell_ent[i])
      );
   end

   rpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_ent    (req_ent),
      .head_ent   (cell_ent[0]),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .ctl        (ctl),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_ent    (rsp_ent)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {rsp_ent.ptype, rsp_ent.stamp, rsp_ent.pid};

endmodule

@@ test/testbench.sv @@
module testbench;
   import rpt_pkg::*;

   // One request transaction as the driver presents it.
   typedef struct packed {
      kind_type  kind;
      entry_type ent;
   } table_req_type;

   // One response transaction as the predictor expects it.
   typedef struct packed {
      status_type status;
      entry_type  ent;
   } table_rsp_type;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_PAUSE = DEPTH + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [KIND_W-1:0]   req_tuser = '0;
   logic [71:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [STATUS_W-1:0] rsp_tuser;
   logic [71:0]         rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [STAMP_W-1:0]  csr_data = '0;

   // Predictor state: the packets still waiting for an acknowledgement, oldest
   // first, and the timeout currently programmed into the block.
   entry_type          pending_table[$];
   logic [STAMP_W-1:0] timeout_setting = TIMEOUT_RESET;

   table_req_type req_backlog[$];
   table_rsp_type due_responses[$];
   table_req_type offered_req;

   int idle_pct = 21;
   int stall_requests = 0;
   int stall_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int errors = 0;

   // Generator state: a running clock and packet id so that most traffic looks
   // like a real sender, plus recent ids and stamps to aim acks and polls at.
   logic [PID_W-1:0]   gen_pid = '0;
   logic [STAMP_W-1:0] gen_clock = '0;
   logic [PID_W-1:0]   recent_pids[$];
   logic [STAMP_W-1:0] recent_stamps[$];

   retransmit_pending_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Applies one accepted request to the predicted table and returns the
   // response the block owes for it.
   function automatic table_rsp_type table_apply(table_req_type rq);
      table_rsp_type      rs;
      logic [STAMP_W-1:0] age;
      rs.status = STAT_ADDED;
      rs.ent = '0;
      case (rq.kind)
         KIND_ADD: begin
            if (pending_table.size() < DEPTH) begin
               pending_table.push_back(rq.ent);
            end else begin
               rs.status = STAT_FULL;
            end
         end
         KIND_ACK: begin
            // The walk stops at the first equal id or at a larger one.
            rs.status = STAT_NOT_FOUND;
            for (int i = 0; i < pending_table.size(); i++) begin
               if (pending_table[i].pid == rq.ent.pid) begin
                  rs.status = STAT_ACKED;
                  rs.ent = pending_table[i];
                  pending_table.delete(i);
                  break;
               end
               if (pending_table[i].pid > rq.ent.pid) break;
            end
         end
         KIND_POLL: begin
            rs.status = STAT_NONE_DUE;
            if (pending_table.size() != 0) begin
               age = rq.ent.stamp - pending_table[0].stamp;
               if (age >= timeout_setting) begin
                  rs.status = STAT_TIMED_OUT;
                  rs.ent = pending_table.pop_front();
               end
            end
         end
         default: begin
            pending_table.delete();
            rs.status = STAT_CLEARED;
         end
      endcase
      return rs;
   endfunction

   task automatic queue_req(kind_type kind, logic [PID_W-1:0] pid,
                            logic [STAMP_W-1:0] stamp, logic [TYPE_W-1:0] ptype);
      table_req_type rq;
      rq.kind = kind;
      rq.ent.pid = pid;
      rq.ent.stamp = stamp;
      rq.ent.ptype = ptype;
      req_backlog.push_back(rq);
   endtask

   // Mostly well-formed traffic: rising ids and times, acks aimed at ids that
   // were added, polls near the timeout boundary; a few items are pure noise.
   function automatic table_req_type random_request();
      table_req_type rq;
      int            roll;
      roll = $urandom_range(0, 99);
      rq.ent.pid = $urandom;
      rq.ent.stamp = $urandom;
      rq.ent.ptype = TYPE_W'($urandom_range(0, 255));
      if (roll < 5) begin
         rq.kind = kind_type'($urandom_range(0, 3));
      end else if (roll < 45) begin
         rq.kind = KIND_ADD;
         gen_pid += $urandom_range(0, 3);
         gen_clock += $urandom_range(0, 20);
         rq.ent.pid = gen_pid;
         rq.ent.stamp = gen_clock;
         recent_pids.push_back(gen_pid);
         recent_stamps.push_back(gen_clock);
         if (recent_pids.size() > 48) begin
            void'(recent_pids.pop_front());
            void'(recent_stamps.pop_front());
         end
      end else if (roll < 73) begin
         rq.kind = KIND_ACK;
         if (recent_pids.size() != 0 && $urandom_range(0, 99) < 85) begin
            rq.ent.pid = recent_pids[$urandom_range(0, recent_pids.size() - 1)];
         end else begin
            rq.ent.pid = gen_pid - $urandom_range(0, 40);
         end
      end else if (roll < 97) begin
         rq.kind = KIND_POLL;
         gen_clock += $urandom_range(0, 10);
         if (recent_stamps.size() != 0 && $urandom_range(0, 1) == 0) begin
            // Land within one tick of the boundary of some recent entry.
            rq.ent.stamp = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)]
                           + timeout_setting + $urandom_range(0, 2) - 1;
         end else begin
            rq.ent.stamp = gen_clock;
         end
      end else begin
         rq.kind = KIND_CLEAR;
      end
      return rq;
   endfunction

   // Returns once no request waits, none is on the bus and no response is owed.
   task automatic wait_drained();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid || due_responses.size() != 0);
   endtask

   task automatic write_timeout(logic [STAMP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      timeout_setting = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(int count);
      repeat (count) req_backlog.push_back(random_request());
   endtask

   // Request driver: records the transaction accepted at this edge, then
   // offers the next backlog item unless it idles this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_responses.push_back(table_apply(offered_req));
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               offered_req = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= offered_req.kind;
               req_tdata <= offered_req.ent;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls, plus a long hold-off whenever one is asked.
   always @(posedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // Response checker against the oldest owed response.
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_responses.size() == 0) begin
            $error("unexpected response transaction, status %0d", rsp_tuser);
            errors++;
         end else begin
            want = due_responses.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.ent.pid) begin
               $error("out_pid: expected %0h, got %0h", want.ent.pid, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.ent.stamp) begin
               $error("out_stamp: expected %0h, got %0h", want.ent.stamp, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[71:64] !== want.ent.ptype) begin
               $error("out_type: expected %0h, got %0h", want.ent.ptype, rsp_tdata[71:64]);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed checks with the reset timeout of 100.
      queue_req(KIND_POLL,  32'd0, 32'd0, 8'd0);              // poll on an empty table
      queue_req(KIND_ACK,   32'd5, 32'd0, 8'd0);              // ack on an empty table
      queue_req(KIND_CLEAR, 32'd0, 32'd0, 8'd0);              // clear while empty
      queue_req(KIND_ADD,   32'd0, 32'd0, 8'd0);
      queue_req(KIND_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      queue_req(KIND_ACK,   32'd3, 32'd0, 8'd0);              // stops at a larger id
      queue_req(KIND_ACK,   32'd0, 32'd0, 8'd0);
      queue_req(KIND_ADD,   32'd7, 32'd1, 8'd1);
      queue_req(KIND_ACK,   32'd7, 32'd0, 8'd0);              // hidden behind a larger id
      queue_req(KIND_POLL,  32'd0, 32'h62, 8'd0);             // one tick short, across wrap
      queue_req(KIND_POLL,  32'd0, 32'h63, 8'd0);             // exactly due
      queue_req(KIND_ADD,   32'd7, 32'd2, 8'd2);              // duplicate id
      queue_req(KIND_ACK,   32'd7, 32'd0, 8'd0);              // oldest duplicate goes first
      queue_req(KIND_ACK,   32'd7, 32'd0, 8'd0);
      queue_req(KIND_ADD,   32'd9, 32'hFFFF_FFF0, 8'hA5);
      queue_req(KIND_POLL,  32'd0, 32'h10, 8'd0);             // wrapped age of 32
      queue_req(KIND_POLL,  32'd0, 32'h60, 8'd0);             // wrapped age of 112
      queue_req(KIND_ADD,   32'd1, 32'd0, 8'h5A);
      queue_req(KIND_ADD,   32'd2, 32'd0, 8'hC3);
      queue_req(KIND_CLEAR, 32'd0, 32'd0, 8'd0);              // clear while holding entries
      queue_req(KIND_POLL,  32'd0, 32'd0, 8'd0);
      queue_req(KIND_ACK,   32'd1, 32'd0, 8'd0);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      // Zero timeout: the oldest entry is always due.
      write_timeout('0);
      queue_random(110);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      // Largest timeout; fill the table past full while the response side
      // holds off, so the block backs up and stalls its request channel.
      write_timeout('1);
      queue_req(KIND_CLEAR, 32'd0, 32'd0, 8'd0);
      stall_requests++;
      for (int i = 0; i < DEPTH + 8; i++) begin
         gen_pid += 1;
         gen_clock += $urandom_range(0, 5);
         queue_req(KIND_ADD, gen_pid, gen_clock, TYPE_W'($urandom_range(0, 255)));
         recent_pids.push_back(gen_pid);
         recent_stamps.push_back(gen_clock);
      end
      queue_random(80);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      // No idling on either side, time running across the 32-bit wrap.
      idle_pct = 0;
      gen_clock = 32'hFFFF_FE00;
      write_timeout(32'd50);
      queue_random(120);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      idle_pct = 21;
      write_timeout($urandom_range(20, 400));
      queue_random(120);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      write_timeout(32'd1000);
      queue_random(110);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clock);

      if (errors == 0 && due_responses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
